>>> hdl/wlss_pkg.sv
// Shared types and constants for the window largest segment select unit.
// Used by wlss_cell and window_largest_segment_select_unit; no dependencies.
`default_nettype none

package wlss_pkg;

   // Width of a per-label pixel count and the largest value that field holds
   localparam int CNT_W         = 11;
   localparam int CNT_FIELD_MAX = 2047;

   // Control part of the search token that walks the cell chain
   typedef struct packed {
      logic valid;   // token present in this stage
      logic done;    // a cell has matched or claimed the label
      logic fresh;   // the label was appended as a new entry
   } tok_ctrl_type;

   // Top level sequencer states
   typedef enum logic [0:0] {
      ST_IDLE,
      ST_WALK
   } state_type;

endpackage

`default_nettype wire

>>> hdl/wlss_cell.sv
// One cell of the label chain: holds one table entry (label and count).
// Depends on wlss_pkg for the token control struct and the count width.
`default_nettype none

module wlss_cell #(
   parameter int LABEL_BITS = 16,
   parameter int IDX_W      = 6,
   parameter int FILL_W     = 7,
   parameter int CELL_INDEX = 0,
   parameter int COUNT_CAP  = 1024
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [FILL_W-1:0]          fill_count,
   input  wire wlss_pkg::tok_ctrl_type     tok_ctrl_in,
   input  wire logic [LABEL_BITS-1:0]      tok_label_in,
   input  wire logic [wlss_pkg::CNT_W-1:0] tok_count_in,
   input  wire logic [IDX_W-1:0]           tok_index_in,
   output wire wlss_pkg::tok_ctrl_type     tok_ctrl_out,
   output wire logic [LABEL_BITS-1:0]      tok_label_out,
   output wire logic [wlss_pkg::CNT_W-1:0] tok_count_out,
   output wire logic [IDX_W-1:0]           tok_index_out
);

   localparam logic [FILL_W-1:0]          MyIndex = FILL_W'(CELL_INDEX);
   localparam logic [IDX_W-1:0]           MyIdx   = IDX_W'(CELL_INDEX);
   localparam logic [wlss_pkg::CNT_W-1:0] CapVal  = wlss_pkg::CNT_W'(COUNT_CAP);

   logic [LABEL_BITS-1:0]      label_ff, label_in;
   logic [wlss_pkg::CNT_W-1:0] count_ff, count_in;
   wlss_pkg::tok_ctrl_type     ctrl_ff, ctrl_in;
   logic [LABEL_BITS-1:0]      tlabel_ff;
   logic [wlss_pkg::CNT_W-1:0] tcount_ff, tcount_in;
   logic [IDX_W-1:0]           tindex_ff, tindex_in;

   logic occupied;
   logic searching;
   logic match;
   logic claim;

   // Entry is live when it lies below the fill count
   assign occupied  = (MyIndex < fill_count);
   assign searching = tok_ctrl_in.valid && !tok_ctrl_in.done;
   assign match     = searching && occupied && (label_ff == tok_label_in);
   assign claim     = searching && !occupied;

   // Update the entry and stamp the token when it stops here
   always_comb begin
      label_in  = label_ff;
      count_in  = count_ff;
      ctrl_in   = tok_ctrl_in;
      tcount_in = tok_count_in;
      tindex_in = tok_index_in;
      if (match) begin
         if (count_ff < CapVal) begin
            count_in = count_ff + wlss_pkg::CNT_W'(1);
         end
         ctrl_in.done = 1'b1;
         tcount_in    = (count_ff < CapVal) ? count_ff + wlss_pkg::CNT_W'(1) : count_ff;
         tindex_in    = MyIdx;
      end else if (claim) begin
         label_in      = tok_label_in;
         count_in      = wlss_pkg::CNT_W'(1);
         ctrl_in.done  = 1'b1;
         ctrl_in.fresh = 1'b1;
         tcount_in     = wlss_pkg::CNT_W'(1);
         tindex_in     = MyIdx;
      end
   end

   // Hold the entry; write only on match or claim
   always_ff @(posedge clock) begin
      if (match || claim) begin
         label_ff <= label_in;
         count_ff <= count_in;
      end
   end

   // Advance the token to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      tlabel_ff <= tok_label_in;
      tcount_ff <= tcount_in;
      tindex_ff <= tindex_in;
   end

   assign tok_ctrl_out  = ctrl_ff;
   assign tok_label_out = tlabel_ff;
   assign tok_count_out = tcount_ff;
   assign tok_index_out = tindex_ff;

endmodule

`default_nettype wire

>>> hdl/window_largest_segment_select_unit.sv
// Largest segment selector over a window of labelled pixels.
// Channels: req_ (pixel in), rsp_ (selected pixel out), valid/ready each.
// The window is sent twice. Count pass (mode 0): each usable pixel's label
// walks a chain of MAX_SEGMENTS cells, one cell per cycle; the cell holding
// the label counts it, the first empty cell takes a new label. A count pixel
// occupies the unit until its label leaves the last cell; an unusable count
// pixel is taken without a walk. Select pass (mode 1): one pixel per cycle
// unless stalled by rsp_; a match is registered and shown on rsp_ next cycle.
// first (mode 0) clears the table, the best entry and the overflow flag.
// Labels beyond the table size are dropped and table_overflow is raised.
// Reset empties the table and drops any pending result. While rsp_ready is
// low, a held result blocks the next transfer on req_; the output register
// is reloaded in the cycle it is taken.
// Depends on wlss_pkg and wlss_cell.
`default_nettype none

module window_largest_segment_select_unit #(
   parameter int MAX_SEGMENTS      = 64,
   parameter int LABEL_BITS        = 16,
   parameter int MAX_WINDOW_PIXELS = 1024,
   parameter int COORD_BITS        = 12
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output wire logic                       req_ready,
   input  wire logic                       req_mode,
   input  wire logic                       req_first,
   input  wire logic [COORD_BITS-1:0]      req_pixel_x,
   input  wire logic [COORD_BITS-1:0]      req_pixel_y,
   input  wire logic [LABEL_BITS-1:0]      req_segment_label,
   input  wire logic                       req_usable,
   input  wire logic                       req_allowed,
   output wire logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   output wire logic [COORD_BITS-1:0]      rsp_out_x,
   output wire logic [COORD_BITS-1:0]      rsp_out_y,
   output wire logic [LABEL_BITS-1:0]      rsp_winner_label,
   output wire logic [wlss_pkg::CNT_W-1:0] rsp_winner_pixels,
   output wire logic                       rsp_table_overflow
);

   localparam int IdxW     = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int FillW    = $clog2(MAX_SEGMENTS + 1);
   localparam int CountCap = (MAX_WINDOW_PIXELS > wlss_pkg::CNT_FIELD_MAX) ?
                             wlss_pkg::CNT_FIELD_MAX : MAX_WINDOW_PIXELS;

   wlss_pkg::state_type        state_ff, state_in;
   wlss_pkg::tok_ctrl_type     launch_ff, launch_in;
   logic [LABEL_BITS-1:0]      launch_label_ff, launch_label_in;
   logic [FillW-1:0]           entries_ff, entries_in;
   logic [IdxW-1:0]            best_idx_ff, best_idx_in;
   logic [wlss_pkg::CNT_W-1:0] best_cnt_ff, best_cnt_in;
   logic [LABEL_BITS-1:0]      win_label_ff, win_label_in;
   logic                       ovf_ff, ovf_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0]      rsp_x_ff, rsp_x_in;
   logic [COORD_BITS-1:0]      rsp_y_ff, rsp_y_in;
   logic [LABEL_BITS-1:0]      rsp_label_ff, rsp_label_in;
   logic [wlss_pkg::CNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic                       rsp_ovf_ff, rsp_ovf_in;

   wlss_pkg::tok_ctrl_type     ctrl_chain  [0:MAX_SEGMENTS];
   logic [LABEL_BITS-1:0]      label_chain [0:MAX_SEGMENTS];
   logic [wlss_pkg::CNT_W-1:0] cnt_chain   [0:MAX_SEGMENTS];
   logic [IdxW-1:0]            idx_chain   [0:MAX_SEGMENTS];

   logic accept;
   logic tail_valid;
   logic better;

   assign req_ready = (state_ff == wlss_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   // Feed the launched token into the head of the chain
   assign ctrl_chain[0]  = launch_ff;
   assign label_chain[0] = launch_label_ff;
   assign cnt_chain[0]   = '0;
   assign idx_chain[0]   = '0;

   // Row of table cells, one entry each
   for (genvar gi = 0; gi < MAX_SEGMENTS; gi++) begin : g_cell
      wlss_cell #(
         .LABEL_BITS (LABEL_BITS),
         .IDX_W      (IdxW),
         .FILL_W     (FillW),
         .CELL_INDEX (gi),
         .COUNT_CAP  (CountCap)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .fill_count    (entries_ff),
         .tok_ctrl_in   (ctrl_chain[gi]),
         .tok_label_in  (label_chain[gi]),
         .tok_count_in  (cnt_chain[gi]),
         .tok_index_in  (idx_chain[gi]),
         .tok_ctrl_out  (ctrl_chain[gi+1]),
         .tok_label_out (label_chain[gi+1]),
         .tok_count_out (cnt_chain[gi+1]),
         .tok_index_out (idx_chain[gi+1])
      );
   end

   assign tail_valid = ctrl_chain[MAX_SEGMENTS].valid;
   // Larger count wins; on a tie the earlier entry wins
   assign better = (cnt_chain[MAX_SEGMENTS] > best_cnt_ff) ||
                   ((cnt_chain[MAX_SEGMENTS] == best_cnt_ff) &&
                    (idx_chain[MAX_SEGMENTS] < best_idx_ff));

   // Sequencer: next state, bookkeeping and result capture
   always_comb begin
      state_in        = state_ff;
      launch_in       = '0;
      launch_label_in = launch_label_ff;
      entries_in      = entries_ff;
      best_idx_in     = best_idx_ff;
      best_cnt_in     = best_cnt_ff;
      win_label_in    = win_label_ff;
      ovf_in          = ovf_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_x_in        = rsp_x_ff;
      rsp_y_in        = rsp_y_ff;
      rsp_label_in    = rsp_label_ff;
      rsp_cnt_in      = rsp_cnt_ff;
      rsp_ovf_in      = rsp_ovf_ff;
      case (state_ff)
         wlss_pkg::ST_IDLE: begin
            if (accept) begin
               if (!req_mode) begin
                  if (req_first) begin
                     entries_in  = '0;
                     best_idx_in = '0;
                     best_cnt_in = '0;
                     ovf_in      = 1'b0;
                  end
                  if (req_usable) begin
                     launch_in.valid = 1'b1;
                     launch_label_in = req_segment_label;
                     state_in        = wlss_pkg::ST_WALK;
                  end
               end else if ((entries_ff != '0) && req_usable && req_allowed &&
                            (req_segment_label == win_label_ff)) begin
                  rsp_valid_in = 1'b1;
                  rsp_x_in     = req_pixel_x;
                  rsp_y_in     = req_pixel_y;
                  rsp_label_in = win_label_ff;
                  rsp_cnt_in   = best_cnt_ff;
                  rsp_ovf_in   = ovf_ff;
               end
            end
         end
         wlss_pkg::ST_WALK: begin
            // Retire the token when it leaves the last cell
            if (tail_valid) begin
               state_in = wlss_pkg::ST_IDLE;
               if (ctrl_chain[MAX_SEGMENTS].done) begin
                  if (ctrl_chain[MAX_SEGMENTS].fresh) begin
                     entries_in = entries_ff + FillW'(1);
                  end
                  if (better) begin
                     best_idx_in  = idx_chain[MAX_SEGMENTS];
                     best_cnt_in  = cnt_chain[MAX_SEGMENTS];
                     win_label_in = label_chain[MAX_SEGMENTS];
                  end
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = wlss_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wlss_pkg::ST_IDLE;
         launch_ff    <= '0;
         entries_ff   <= '0;
         best_idx_ff  <= '0;
         best_cnt_ff  <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         entries_ff   <= entries_in;
         best_idx_ff  <= best_idx_in;
         best_cnt_ff  <= best_cnt_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      launch_label_ff <= launch_label_in;
      win_label_ff    <= win_label_in;
      rsp_x_ff        <= rsp_x_in;
      rsp_y_ff        <= rsp_y_in;
      rsp_label_ff    <= rsp_label_in;
      rsp_cnt_ff      <= rsp_cnt_in;
      rsp_ovf_ff      <= rsp_ovf_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_x          = rsp_x_ff;
   assign rsp_out_y          = rsp_y_ff;
   assign rsp_winner_label   = rsp_label_ff;
   assign rsp_winner_pixels  = rsp_cnt_ff;
   assign rsp_table_overflow = rsp_ovf_ff;

endmodule

`default_nettype wire
